>>> rtl/ddo_pkg.sv
// package for the differential drive odometry block
// types, constants, cordic arctangent table and clamp helper
`default_nettype none
package ddo_pkg;
	localparam int COUNT_BITS_DEF   = 32;
	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam logic signed [63:0] SAT62       = 64'sh3FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] PI_Q30      = 64'sd3373259426;
	localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;
	localparam logic signed [63:0] TWO_PI_Q30  = 64'sd6746518852;
	localparam logic [63:0]        KINF_Q30    = 64'd652032875;

	localparam logic [1:0] REG_MPT  = 2'd0;
	localparam logic [1:0] REG_RPT  = 2'd1;
	localparam logic [1:0] REG_RATE = 2'd2;

	typedef enum logic [4:0] {
		ST_IDLE, ST_MID, ST_QEST, ST_QMUL, ST_REM, ST_REDUCE, ST_FOLD, ST_CORDIC,
		ST_ACCX, ST_ACCY, ST_OUTX, ST_OUTY, ST_HEAD,
		ST_VLIN, ST_SLIN, ST_VANG, ST_SANG, ST_DONE
	} state_t;

	function automatic logic signed [63:0] atan_q30(input logic [4:0] i);
		case (i)
			5'd0:  atan_q30 = 64'sd843314857;
			5'd1:  atan_q30 = 64'sd497837830;
			5'd2:  atan_q30 = 64'sd263043837;
			5'd3:  atan_q30 = 64'sd133525159;
			5'd4:  atan_q30 = 64'sd67021687;
			5'd5:  atan_q30 = 64'sd33543516;
			5'd6:  atan_q30 = 64'sd16775851;
			5'd7:  atan_q30 = 64'sd8388438;
			5'd8:  atan_q30 = 64'sd4194283;
			5'd9:  atan_q30 = 64'sd2097149;
			default: atan_q30 = (i < 5'd24) ? (64'sd1 << (5'd30 - i)) : 64'sd0;
		endcase
	endfunction

	function automatic logic signed [63:0] clamp_to(input logic signed [63:0] v,
			input logic signed [63:0] lim);
		if (v > lim) clamp_to = lim;
		else if (v < -lim - 64'sd1) clamp_to = -lim - 64'sd1;
		else clamp_to = v;
	endfunction
endpackage
`default_nettype wire

>>> rtl/ddo_if.sv
// valid/ready channel interface used by all ports
// depends on nothing
`default_nettype none
interface ddo_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/ddo_mul.sv
// shared rounding multiplier: round(a*b/2^s) for |b| < 2^32, clamped to +-(2^62-1)
// 32x32 partial products are registered, then combined into the registered result; uses ddo_pkg
`default_nettype none
module ddo_mul
	import ddo_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [63:0] a,
	input  wire logic signed [63:0] b,
	input  wire logic [5:0]         sh,
	output logic                    done,
	output logic signed [63:0]      res
);
	logic        neg_s1, vld_s1;
	logic [5:0]  sh_s1;
	logic [63:0] p0_s1, p1_s1;
	logic [63:0] ua, ub;
	logic [63:0] hi, lo, r;

	assign ua = a[63] ? 64'd0 - a : a;
	assign ub = b[63] ? 64'd0 - b : b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= a[63] ^ b[63];
		sh_s1  <= sh;
		p0_s1  <= {32'd0, ua[31:0]} * {32'd0, ub[31:0]};
		p1_s1  <= {32'd0, ua[63:32]} * {32'd0, ub[31:0]};
	end

	always_comb begin
		hi = p1_s1 + (p0_s1 >> 32);
		lo = {32'd0, p0_s1[31:0]};
		r  = '0;
		if (sh_s1 >= 6'd1 && sh_s1 <= 6'd32) begin
			lo = lo + (64'd1 << (sh_s1 - 6'd1));
			hi = hi + (lo >> 32);
			lo = {32'd0, lo[31:0]};
		end else if (sh_s1 > 6'd32) begin
			hi = hi + (64'd1 << (sh_s1 - 6'd33));
		end
		if (sh_s1 <= 6'd32) begin
			if ((hi >> (7'd30 + {1'b0, sh_s1})) != 64'd0) r = SAT62;
			else r = (hi << (6'd32 - sh_s1)) | (lo >> sh_s1);
		end else begin
			r = hi >> (sh_s1 - 6'd32);
			if (r > SAT62) r = SAT62;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		res <= neg_s1 ? -$signed(r) : $signed(r);
	end
endmodule
`default_nettype wire

>>> rtl/differential_drive_odometry.sv
// differential drive odometry top level: sequencer, cordic datapath, registers
// depends on ddo_pkg, ddo_if, ddo_mul
//
// channel  | dir | payload
// ---------+-----+------------------------------------------------
// cfg      | in  | index (2b), data (32b)
// in_ch    | in  | left_count, right_count
// out_ch   | out | pos_x, pos_y, heading, speed_linear, speed_angular
//
// after accept, three of the twelve products go one after another through the
// shared rounding multiplier, then come the three angle reduction and fold
// steps (rem, reduce, fold), the cordic does one rotation a cycle, and the
// other nine products follow. in_ch is not ready from accept until the result
// is taken, so a new request is not taken while one is in flight. reset clears
// state and sets rate_q to 100. a stalled result holds in the output register.
`default_nettype none
module differential_drive_odometry
	import ddo_pkg::*;
#(
	parameter int COUNT_BITS   = COUNT_BITS_DEF,
	parameter int FRAC_BITS    = FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	ddo_if.sink   cfg,
	ddo_if.sink   in_ch,
	ddo_if.source out_ch
);
	localparam int W     = COUNT_BITS + 1;
	localparam int ACCB  = (COUNT_BITS + FRAC_BITS + 8 > 62) ? 62 : COUNT_BITS + FRAC_BITS + 8;
	localparam logic signed [63:0] ACC_LIM = (64'sd1 <<< (ACCB - 1)) - 64'sd1;
	localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
	localparam logic [63:0] GAIN = KINF_Q30 + ((KINF_Q30 * 64'd2 / 64'd3) >> (2 * CORDIC_STEPS));
	localparam int NSTEP = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
	// floor(2^63 / 2pi in q30), for the quotient estimate of the angle reduction
	localparam logic [63:0] RECIP_2PI = 64'h8000_0000_0000_0000 / 64'(TWO_PI_Q30);

	state_t state_q, state_d;
	logic [31:0] mpt_q, rpt_q;
	logic [15:0] rate_q;
	logic signed [W-1:0] last_sum_q, last_diff_q, dsum_q, ddiff_q, sum_q, diff_q;
	logic signed [ACCB-1:0] accx_q, accy_q;
	logic signed [63:0] x_q, y_q, z_q, v_q, quo_q;
	logic flip_q, mwait_q;
	logic [4:0] it_q;
	logic [31:0] o_x_q, o_y_q, o_h_q, o_l_q, o_a_q;

	logic signed [W-1:0] lw, rw, sumw, diffw;
	logic m_start, m_done;
	logic signed [63:0] m_a, m_b, m_res, acc_new, dx, dy, at, zabs;
	logic [5:0] m_sh;

	assign lw    = W'(in_ch.data.left_count);
	assign rw    = W'(in_ch.data.right_count);
	assign sumw  = lw + rw;
	assign diffw = rw - lw;

	assign cfg.ready   = 1'b1;
	assign in_ch.ready = (state_q == ST_IDLE);
	assign out_ch.valid = (state_q == ST_DONE);

	function automatic logic [31:0] o32(input logic signed [63:0] v);
		o32 = 32'(clamp_to(v, I32_MAX));
	endfunction

	ddo_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(m_start), .a(m_a), .b(m_b),
		.sh(m_sh), .done(m_done), .res(m_res)
	);

	assign zabs = z_q[63] ? -z_q : z_q;

	// operand select for the shared multiplier
	always_comb begin
		m_a = 64'sd0;
		m_b = 64'sd0;
		m_sh = 6'd0;
		case (state_q)
			ST_MID:  begin m_a = 64'(2 * 64'(last_diff_q) + 64'(ddiff_q)); m_b = {32'd0, rpt_q}; m_sh = 6'd4; end
			ST_QEST: begin m_a = zabs; m_b = RECIP_2PI; m_sh = 6'd63; end
			ST_QMUL: begin m_a = TWO_PI_Q30; m_b = quo_q; m_sh = 6'd0; end
			ST_ACCX: begin m_a = 64'(dsum_q); m_b = x_q; m_sh = 6'(31 - FRAC_BITS); end
			ST_ACCY: begin m_a = 64'(dsum_q); m_b = y_q; m_sh = 6'(31 - FRAC_BITS); end
			ST_OUTX: begin m_a = 64'(accx_q); m_b = {32'd0, mpt_q}; m_sh = 6'd32; end
			ST_OUTY: begin m_a = 64'(accy_q); m_b = {32'd0, mpt_q}; m_sh = 6'd32; end
			ST_HEAD: begin m_a = 64'(diff_q); m_b = {32'd0, rpt_q}; m_sh = 6'(33 - FRAC_BITS); end
			ST_VLIN: begin m_a = 64'(dsum_q); m_b = {32'd0, mpt_q}; m_sh = 6'd1; end
			ST_VANG: begin m_a = 64'(ddiff_q); m_b = {32'd0, rpt_q}; m_sh = 6'd1; end
			ST_SLIN, ST_SANG: begin m_a = v_q; m_b = {48'd0, rate_q}; m_sh = 6'(32 - FRAC_BITS); end
			default: ;
		endcase
	end

	assign m_start = !mwait_q && (state_q == ST_MID || state_q == ST_QEST ||
		state_q == ST_QMUL || state_q == ST_ACCX ||
		state_q == ST_ACCY || state_q == ST_OUTX || state_q == ST_OUTY ||
		state_q == ST_HEAD || state_q == ST_VLIN || state_q == ST_SLIN ||
		state_q == ST_VANG || state_q == ST_SANG);

	assign dx = y_q >>> it_q;
	assign dy = x_q >>> it_q;
	assign at = atan_q30(it_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_ch.valid) state_d = ST_MID;
			ST_MID:    if (m_done) state_d = ST_QEST;
			ST_QEST:   if (m_done) state_d = ST_QMUL;
			ST_QMUL:   if (m_done) state_d = ST_REM;
			ST_REM:    state_d = ST_REDUCE;
			ST_REDUCE: state_d = ST_FOLD;
			ST_FOLD:   state_d = (NSTEP == 0) ? ST_ACCX : ST_CORDIC;
			ST_CORDIC: if (it_q == 5'(NSTEP - 1)) state_d = ST_ACCX;
			ST_ACCX:   if (m_done) state_d = ST_ACCY;
			ST_ACCY:   if (m_done) state_d = ST_OUTX;
			ST_OUTX:   if (m_done) state_d = ST_OUTY;
			ST_OUTY:   if (m_done) state_d = ST_HEAD;
			ST_HEAD:   if (m_done) state_d = ST_VLIN;
			ST_VLIN:   if (m_done) state_d = ST_SLIN;
			ST_SLIN:   if (m_done) state_d = ST_VANG;
			ST_VANG:   if (m_done) state_d = ST_SANG;
			ST_SANG:   if (m_done) state_d = ST_DONE;
			ST_DONE:   if (out_ch.ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mwait_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (m_done) mwait_q <= 1'b0;
			else if (m_start) mwait_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpt_q <= '0;
			rpt_q <= '0;
			rate_q <= 16'd100;
			last_sum_q <= '0;
			last_diff_q <= '0;
			accx_q <= '0;
			accy_q <= '0;
		end else begin
			if (cfg.valid) begin
				case (cfg.data.index)
					REG_MPT:  mpt_q <= cfg.data.data;
					REG_RPT:  rpt_q <= cfg.data.data;
					REG_RATE: rate_q <= cfg.data.data[15:0];
					default: ;
				endcase
			end
			// the midpoint angle needs the previous difference, so update after it
			if (state_q == ST_MID && m_done) begin
				last_sum_q <= sum_q;
				last_diff_q <= diff_q;
			end
			if (state_q == ST_ACCX && m_done) accx_q <= ACCB'(acc_new);
			if (state_q == ST_ACCY && m_done) accy_q <= ACCB'(acc_new);
		end
	end

	assign acc_new = clamp_to((state_q == ST_ACCX ? 64'(accx_q) : 64'(accy_q)) + m_res, ACC_LIM);

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sum_q <= sumw;
				diff_q <= diffw;
				dsum_q <= sumw - last_sum_q;
				ddiff_q <= diffw - last_diff_q;
			end
			ST_MID: if (m_done) z_q <= m_res;
			// quotient estimate one low so the remainder lands in [0, 4pi)
			ST_QEST: if (m_done) quo_q <= (m_res == 64'sd0) ? 64'sd0 : m_res - 64'sd1;
			ST_QMUL: if (m_done) z_q <= z_q[63] ? m_res - zabs : zabs - m_res;
			ST_REM: begin
				if (z_q >= TWO_PI_Q30) z_q <= z_q - TWO_PI_Q30;
				else if (z_q <= -TWO_PI_Q30) z_q <= z_q + TWO_PI_Q30;
			end
			ST_REDUCE: begin
				if (z_q > PI_Q30) z_q <= z_q - TWO_PI_Q30;
				else if (z_q < -PI_Q30) z_q <= z_q + TWO_PI_Q30;
			end
			ST_FOLD: begin
				flip_q <= 1'b0;
				if (z_q > HALF_PI_Q30) begin z_q <= z_q - PI_Q30; flip_q <= 1'b1; end
				else if (z_q < -HALF_PI_Q30) begin z_q <= z_q + PI_Q30; flip_q <= 1'b1; end
				x_q <= GAIN;
				y_q <= 64'sd0;
				it_q <= 5'd0;
			end
			ST_CORDIC: begin
				if (!z_q[63]) begin
					x_q <= x_q - dx; y_q <= y_q + dy; z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx; y_q <= y_q - dy; z_q <= z_q + at;
				end
				it_q <= it_q + 5'd1;
				if (it_q == 5'(NSTEP - 1) && flip_q) begin
					x_q <= -(z_q[63] ? x_q + dx : x_q - dx);
					y_q <= -(z_q[63] ? y_q - dy : y_q + dy);
				end
			end
			ST_OUTX: if (m_done) o_x_q <= o32(m_res);
			ST_OUTY: if (m_done) o_y_q <= o32(m_res);
			ST_HEAD: if (m_done) o_h_q <= o32(m_res);
			ST_VLIN, ST_VANG: if (m_done) v_q <= m_res;
			ST_SLIN: if (m_done) o_l_q <= o32(m_res);
			ST_SANG: if (m_done) o_a_q <= o32(m_res);
			default: ;
		endcase
	end

	assign out_ch.data.pos_x = o_x_q;
	assign out_ch.data.pos_y = o_y_q;
	assign out_ch.data.heading = o_h_q;
	assign out_ch.data.speed_linear = o_l_q;
	assign out_ch.data.speed_angular = o_a_q;
endmodule
`default_nettype wire

>>> tb/tb_ddo_types.sv
// request and result payload types for the odometry testbench
// depends on nothing; used by tb_top to parameterize the ddo_if channels
`timescale 1ns / 1ps
package tb_ddo_types;
	typedef struct packed {
		logic [1:0]  index;
		logic [31:0] data;
	} cfg_req_t;

	typedef struct packed {
		logic signed [31:0] left_count;
		logic signed [31:0] right_count;
	} count_req_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] heading;
		logic signed [31:0] speed_linear;
		logic signed [31:0] speed_angular;
	} pose_t;
endpackage

>>> tb/tb_top.sv
// self-checking testbench for differential_drive_odometry
// depends on ddo_pkg, ddo_if, tb_ddo_types; predicts every pose and compares on output
`timescale 1ns / 1ps
module tb_top;
	import ddo_pkg::*;
	import tb_ddo_types::*;

	localparam int  CSTEPS    = 16;
	localparam int  FBITS     = 16;
	localparam int  MAX_CYCLE = 1500000;
	localparam int  DRAIN     = 80;
	localparam longint ACC_LIM = (64'sd1 <<< 55) - 1;
	localparam longint ATAN_TBL [24] = '{
		843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388438, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768, 16384, 8192,
		4096, 2048, 1024, 512, 256, 128};

	logic clk;
	logic arst_n;

	ddo_if #(.T(cfg_req_t))   cfg_ch ();
	ddo_if #(.T(count_req_t)) in_ch ();
	ddo_if #(.T(pose_t))      out_ch ();

	differential_drive_odometry dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// predictor copy of registers and state
	longint mpt_reg, rpt_reg, rate_reg;
	longint prev_sum, prev_diff, x_ticks, y_ticks;

	count_req_t pending_counts[$];
	pose_t      expected_poses[$];
	int         errors;
	int         cycles;
	int         send_idle_pct, recv_stall_pct;
	bit         took;
	bit         hold_req;
	longint     walk_l, walk_r;

	function automatic longint round_mul(longint a, longint b, int s);
		logic [127:0] p;
		logic [63:0]  ua, ub;
		logic         neg;
		neg = (a < 0) != (b < 0);
		ua  = (a < 0) ? -a : a;
		ub  = (b < 0) ? -b : b;
		p   = {64'd0, ua} * {64'd0, ub};
		if (s > 0)
			p = p + (128'd1 << (s - 1));
		p = p >> s;
		if (p > 128'(SAT62))
			p = 128'(SAT62);
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint sat_to(longint v, longint lim);
		if (v > lim) return lim;
		if (v < -lim - 1) return -lim - 1;
		return v;
	endfunction

	function automatic longint wrap33(longint v);
		logic signed [32:0] t;
		t = v[32:0];
		return t;
	endfunction

	function automatic logic signed [31:0] to_q16(longint v);
		longint c;
		c = sat_to(v, 64'sd2147483647);
		return c[31:0];
	endfunction

	task automatic rotate_angle(input longint ang, output longint c, output longint s);
		longint x, y, z, dx, dy;
		logic [63:0] gain;
		bit flip;
		flip = 0;
		gain = KINF_Q30 + ((KINF_Q30 * 2 / 3) >> (2 * CSTEPS));
		z = ang % TWO_PI_Q30;
		if (z > PI_Q30) z -= TWO_PI_Q30;
		if (z < -PI_Q30) z += TWO_PI_Q30;
		if (z > HALF_PI_Q30) begin
			z -= PI_Q30;
			flip = 1;
		end else if (z < -HALF_PI_Q30) begin
			z += PI_Q30;
			flip = 1;
		end
		x = gain;
		y = 0;
		for (int i = 0; i < CSTEPS && i < 24; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= ATAN_TBL[i];
			end else begin
				x += dx; y -= dy; z += ATAN_TBL[i];
			end
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	task automatic predict_pose(input count_req_t req, output pose_t p);
		longint l, r, sum, diff, dsum, ddiff, mid, c, s, v;
		l = req.left_count;
		r = req.right_count;
		sum = l + r;
		diff = r - l;
		dsum = wrap33(sum - prev_sum);
		ddiff = wrap33(diff - prev_diff);
		mid = round_mul(2 * prev_diff + ddiff, rpt_reg, 4);
		rotate_angle(mid, c, s);
		x_ticks = sat_to(x_ticks + round_mul(dsum, c, 31 - FBITS), ACC_LIM);
		y_ticks = sat_to(y_ticks + round_mul(dsum, s, 31 - FBITS), ACC_LIM);
		prev_sum = sum;
		prev_diff = diff;
		p.pos_x = to_q16(round_mul(x_ticks, mpt_reg, 32));
		p.pos_y = to_q16(round_mul(y_ticks, mpt_reg, 32));
		p.heading = to_q16(round_mul(diff, rpt_reg, 33 - FBITS));
		v = round_mul(dsum, mpt_reg, 1);
		p.speed_linear = to_q16(round_mul(v, rate_reg, 32 - FBITS));
		v = round_mul(ddiff, rpt_reg, 1);
		p.speed_angular = to_q16(round_mul(v, rate_reg, 32 - FBITS));
	endtask

	task automatic report(input string field, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > MAX_CYCLE) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// request driver: predicts each accepted request, then drives the next
	always @(posedge clk) begin
		pose_t p;
		if (in_ch.valid && in_ch.ready) begin
			predict_pose(in_ch.data, p);
			expected_poses.push_back(p);
			took = 1;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (took || !in_ch.valid) begin
			took = 0;
			if (pending_counts.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_ch.valid <= 1'b1;
				in_ch.data  <= pending_counts.pop_front();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// long receiver hold-off, counted here
	always @(posedge clk) begin
		if (hold_req) begin
			repeat (400) @(posedge clk);
			hold_req = 0;
		end
	end

	always @(negedge clk) begin
		out_ch.ready <= arst_n && !hold_req && ($urandom_range(99) >= recv_stall_pct);
	end

	// result monitor
	always @(posedge clk) begin
		pose_t want, got;
		if (out_ch.valid && out_ch.ready) begin
			got = out_ch.data;
			if (expected_poses.size() == 0) begin
				report("unexpected pose", got.pos_x, 0);
			end else begin
				want = expected_poses.pop_front();
				if (got.pos_x !== want.pos_x) report("pos_x", got.pos_x, want.pos_x);
				if (got.pos_y !== want.pos_y) report("pos_y", got.pos_y, want.pos_y);
				if (got.heading !== want.heading)
					report("heading", got.heading, want.heading);
				if (got.speed_linear !== want.speed_linear)
					report("speed_linear", got.speed_linear, want.speed_linear);
				if (got.speed_angular !== want.speed_angular)
					report("speed_angular", got.speed_angular, want.speed_angular);
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{index: idx, data: val};
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_MPT:  mpt_reg = val;
			REG_RPT:  rpt_reg = val;
			REG_RATE: rate_reg = val[15:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_counts.size() > 0 || in_ch.valid || expected_poses.size() > 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic push_counts(input longint l, input longint r);
		count_req_t q;
		q.left_count = l[31:0];
		q.right_count = r[31:0];
		walk_l = q.left_count;
		walk_r = q.right_count;
		pending_counts.push_back(q);
	endtask

	// mostly a wheel walk with small steps, some big jumps and raw noise
	task automatic push_random();
		int pick;
		pick = $urandom_range(99);
		if (pick < 80) begin
			int base, turn;
			base = $urandom_range(4000) - 2000;
			turn = $urandom_range(600) - 300;
			push_counts(walk_l + base - turn, walk_r + base + turn);
		end else if (pick < 90) begin
			push_counts(walk_l + $signed($urandom()), walk_r + $signed($urandom() >> 1));
		end else begin
			push_counts($signed($urandom()), $signed($urandom()));
		end
	endtask

	initial begin
		logic [31:0] mpt_set [8];
		logic [31:0] rpt_set [8];
		logic [15:0] rate_set[8];
		errors = 0;
		cycles = 0;
		took = 0;
		hold_req = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		walk_l = 0;
		walk_r = 0;
		mpt_reg = 0;
		rpt_reg = 0;
		rate_reg = 100;
		prev_sum = 0;
		prev_diff = 0;
		x_ticks = 0;
		y_ticks = 0;
		arst_n = 0;
		cfg_ch.valid = 0;
		cfg_ch.data = '0;
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset settings first: zero scales give zero outputs
		push_counts(1000, 3000);
		push_counts(-5, 7);
		wait_drained();

		write_reg(REG_MPT, 32'd429497);
		write_reg(REG_RPT, 32'd2147484);
		push_counts(0, 0);
		push_counts(2147483647, 2147483647);
		push_counts(-2147483648, -2147483648);
		push_counts(-2147483648, 2147483647);
		push_counts(2147483647, -2147483648);
		push_counts(0, 0);
		push_counts(100, -100);
		push_counts(200, -200);
		wait_drained();

		// extreme scales and rates
		write_reg(REG_MPT, 32'hFFFF_FFFF);
		write_reg(REG_RPT, 32'hFFFF_FFFF);
		write_reg(REG_RATE, 16'hFFFF);
		push_counts(2147483647, -2147483648);
		push_counts(-2147483648, 2147483647);
		push_counts(2147483647, 2147483647);
		push_counts(-2147483648, -2147483648);
		for (int i = 0; i < 6; i++)
			push_counts(walk_l + 1000000000, walk_r + 1000000000);
		wait_drained();
		write_reg(REG_RATE, 16'd0);
		push_counts(12345, -54321);
		push_counts(-7, 99999);
		wait_drained();

		mpt_set  = '{32'd429497, 32'd1, 32'hFFFF_FFFF, 32'd0,
		             32'd42950, 32'h8000_0000, 32'd4294967, 32'd0};
		rpt_set  = '{32'd2147484, 32'hFFFF_FFFF, 32'd1, 32'd21474836,
		             32'd0, 32'h4000_0000, 32'd429497, 32'd0};
		rate_set = '{16'd100, 16'd1, 16'hFFFF, 16'd1000,
		             16'd0, 16'd500, 16'd50, 16'd200};

		for (int ph = 0; ph < 8; ph++) begin
			logic [31:0] m, r;
			logic [15:0] hz;
			m = mpt_set[ph];
			r = rpt_set[ph];
			hz = rate_set[ph];
			if (ph == 7) begin
				m = $urandom();
				r = $urandom();
				hz = 16'($urandom());
			end
			write_reg(REG_MPT, m);
			write_reg(REG_RPT, r);
			write_reg(REG_RATE, {16'd0, hz});
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
				default: begin send_idle_pct = 29; recv_stall_pct = 29; end
			endcase
			for (int k = 0; k < 165; k++) begin
				push_random();
				if (ph == 0 && k == 20)
					hold_req = 1;
				while (pending_counts.size() > 4)
					@(posedge clk);
			end
			wait_drained();
		end

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule

>>> sim.f
rtl/ddo_pkg.sv
rtl/ddo_if.sv
rtl/ddo_mul.sv
rtl/differential_drive_odometry.sv
tb/tb_ddo_types.sv
tb/tb_top.sv
